// ----- hw/rtl/inverted_index_token_insert_defines.svh -----
// assertion macros shared by the index insert rtl
`ifndef INVERTED_INDEX_TOKEN_INSERT_DEFINES_SVH
`define INVERTED_INDEX_TOKEN_INSERT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IIT_ASSERT_IMPLY(name, clk, rst_n, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("index insert check failed");
// next-cycle implication
`define IIT_ASSERT_NEXT(name, clk, rst_n, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("index insert check failed");
`else
`define IIT_ASSERT_IMPLY(name, clk, rst_n, a, c)
`define IIT_ASSERT_NEXT(name, clk, rst_n, a, c)
`endif
`endif

// ----- hw/rtl/iit_pkg.sv -----
// shared constants and types of the index insert block
package iit_pkg;
    localparam int TERMS_DEF = 1024;
    localparam int POSTINGS_PER_TERM_DEF = 64;
    localparam int DOCS_DEF = 1024;
    localparam int TERM_CHARS_DEF = 32;
    localparam int MAX_TOKEN_CHARS_DEF = 100;

    localparam logic [6:0] LEN_MAX = 7'd127;
    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_END    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_TOKEN  = 2'd0,
        JOB_IGNORE = 2'd1,
        JOB_CLEAR  = 2'd2
    } job_kind_t;

    typedef enum logic [2:0] {
        ST_NEW        = 3'd0,
        ST_FREQ       = 3'd1,
        ST_ADDED      = 3'd2,
        ST_POST_FULL  = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_TOO_LONG   = 3'd5,
        ST_IGNORED    = 3'd6,
        ST_CLEARED    = 3'd7
    } status_t;
endpackage

// ----- hw/rtl/iit_if.sv -----
// request and result channel interfaces of the index insert block
interface iit_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] token_char;
    logic [9:0] doc_id;
    modport source (output valid, cmd, token_char, doc_id, input ready);
    modport sink (input valid, cmd, token_char, doc_id, output ready);
endinterface

interface iit_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  term_index;
    logic [15:0] posting_freq;
    logic [15:0] doc_length;
    logic [10:0] term_count;
    logic [31:0] token_total;
    modport source (output valid, status, term_index, posting_freq, doc_length,
                    term_count, token_total, input ready);
    modport sink (input valid, status, term_index, posting_freq, doc_length,
                  term_count, token_total, output ready);
endinterface

// ----- hw/rtl/iit_ram.sv -----
// generic single write port ram with registered read
module iit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/iit_queue.sv -----
// small job queue between the front and back parts
module iit_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = 32'(fill_reg) < DEPTH;
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wr_next = (32'(wr_reg) == DEPTH - 1) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (32'(rd_reg) == DEPTH - 1) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end
endmodule

// ----- hw/rtl/iit_front.sv -----
// front part: collects token bytes and classifies finished requests
module iit_front #(
    parameter int TERM_CHARS      = iit_pkg::TERM_CHARS_DEF,
    parameter int MAX_TOKEN_CHARS = iit_pkg::MAX_TOKEN_CHARS_DEF,
    parameter int DOCS            = iit_pkg::DOCS_DEF,
    parameter int JOB_W           = 19 + 8 * TERM_CHARS
) (
    input  logic             clk,
    input  logic             rst_n,
    iit_in_if.sink           tok,
    input  logic             enable,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [JOB_W-1:0] push_data
);
    localparam int BW = $clog2(TERM_CHARS);

    logic [7:0]              tbuf_reg [TERM_CHARS];
    logic [6:0]              len_reg, len_next;
    logic [8*TERM_CHARS-1:0] bytes;
    logic                    acc;
    iit_pkg::cmd_t           cmd;
    iit_pkg::job_kind_t      kind;

    assign tok.ready = enable && push_ready;
    assign acc       = tok.valid && tok.ready;
    assign cmd       = iit_pkg::cmd_t'(tok.cmd);

    // flatten the token buffer
    always_comb
    begin
        for (int j = 0; j < TERM_CHARS; j++)
        begin
            bytes[j*8 +: 8] = tbuf_reg[j];
        end
    end

    // classify and track token length
    always_comb
    begin
        len_next   = len_reg;
        kind       = iit_pkg::JOB_IGNORE;
        push_valid = 1'b0;
        unique case (cmd)
            iit_pkg::CMD_APPEND:
            begin
                if (acc && len_reg != iit_pkg::LEN_MAX)
                begin
                    len_next = len_reg + 7'd1;
                end
            end
            iit_pkg::CMD_END:
            begin
                push_valid = acc;
                if (acc)
                begin
                    len_next = '0;
                end
                if (len_reg == '0 || 32'(len_reg) > MAX_TOKEN_CHARS
                    || 32'(tok.doc_id) >= DOCS)
                begin
                    kind = iit_pkg::JOB_IGNORE;
                end
                else
                begin
                    kind = iit_pkg::JOB_TOKEN;
                end
            end
            iit_pkg::CMD_CLEAR:
            begin
                push_valid = acc;
                kind       = iit_pkg::JOB_CLEAR;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

    assign push_data = {kind, len_reg, tok.doc_id, bytes};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // byte store while room is left
    always_ff @(posedge clk)
    begin
        if (acc && cmd == iit_pkg::CMD_APPEND && 32'(len_reg) < TERM_CHARS)
        begin
            tbuf_reg[len_reg[BW-1:0]] <= tok.token_char;
        end
    end
endmodule

// ----- hw/rtl/iit_back.sv -----
// back part: term scan, posting update, document lengths and results
`include "inverted_index_token_insert_defines.svh"
module iit_back #(
    parameter int TERMS             = iit_pkg::TERMS_DEF,
    parameter int POSTINGS_PER_TERM = iit_pkg::POSTINGS_PER_TERM_DEF,
    parameter int DOCS              = iit_pkg::DOCS_DEF,
    parameter int TERM_CHARS        = iit_pkg::TERM_CHARS_DEF,
    parameter int JOB_W             = 19 + 8 * TERM_CHARS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  logic [JOB_W-1:0] pop_data,
    output logic             init_done,
    iit_out_if.source        res
);
    localparam int BYW  = 8 * TERM_CHARS;
    localparam int SW   = $clog2(TERMS);
    localparam int CW   = $clog2(TERMS + 1);
    localparam int LW   = $clog2(TERM_CHARS);
    localparam int TROW = BYW + LW;
    localparam int PPW  = $clog2(POSTINGS_PER_TERM + 1);
    localparam int PAW  = $clog2(TERMS * POSTINGS_PER_TERM);
    localparam int DAW  = $clog2(DOCS);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_TRD, S_TCMP, S_NEW,
        S_PRD, S_PCMP, S_PEND, S_DOC, S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [6:0]         len_reg, len_next;
    logic [9:0]         doc_reg, doc_next;
    logic [BYW-1:0]     bytes_reg, bytes_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [PAW-1:0]     base_reg, base_next;
    logic [PPW-1:0]     pj_reg, pj_next;
    logic [PPW-1:0]     used_reg, used_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [31:0]        total_reg, total_next;
    iit_pkg::status_t   status_reg, status_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [15:0]        freq_reg, freq_next;
    logic [15:0]        dlen_reg, dlen_next;
    logic               bump_reg, bump_next;
    logic [DAW-1:0]     clr_reg, clr_next;
    logic               ovalid_reg, ovalid_next;
    logic [2:0]         ostatus_reg, ostatus_next;
    logic [9:0]         oindex_reg, oindex_next;
    logic [15:0]        ofreq_reg, ofreq_next;
    logic [15:0]        odlen_reg, odlen_next;
    logic [10:0]        ocount_reg, ocount_next;
    logic [31:0]        ototal_reg, ototal_next;

    iit_pkg::job_kind_t job_kind;
    logic [6:0]         job_len;
    logic               match;
    logic [15:0]        cnt_inc;
    logic [15:0]        dlen_inc;

    logic               t_we;
    logic [TROW-1:0]    t_rdata;
    logic               u_we;
    logic [SW-1:0]      u_waddr;
    logic [PPW-1:0]     u_wdata, u_rdata;
    logic               p_we;
    logic [PAW-1:0]     p_addr;
    logic [25:0]        p_wdata, p_rdata;
    logic               d_we;
    logic [DAW-1:0]     d_waddr;
    logic [15:0]        d_wdata, d_rdata;

    // term rows: length over bytes
    iit_ram #(.WIDTH(TROW), .DEPTH(TERMS)) u_term_ram (
        .clk(clk), .we(t_we), .waddr(count_reg[SW-1:0]),
        .wdata({len_reg[LW-1:0], bytes_reg}),
        .raddr(idx_reg[SW-1:0]), .rdata(t_rdata)
    );

    // postings in use per term
    iit_ram #(.WIDTH(PPW), .DEPTH(TERMS)) u_used_ram (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .raddr(idx_reg[SW-1:0]), .rdata(u_rdata)
    );

    // postings: document over count
    iit_ram #(.WIDTH(26), .DEPTH(TERMS * POSTINGS_PER_TERM)) u_post_ram (
        .clk(clk), .we(p_we), .waddr(p_addr), .wdata(p_wdata),
        .raddr(p_addr), .rdata(p_rdata)
    );

    // per-document token lengths
    iit_ram #(.WIDTH(16), .DEPTH(DOCS)) u_doc_ram (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(DAW'(doc_reg)), .rdata(d_rdata)
    );

    assign job_kind  = iit_pkg::job_kind_t'(pop_data[JOB_W-1 -: 2]);
    assign job_len   = pop_data[BYW+10 +: 7];
    assign pop_ready = state_reg == S_IDLE;
    assign init_done = state_reg != S_INIT;
    assign p_addr    = base_reg + PAW'(pj_reg);
    assign cnt_inc   = (p_rdata[15:0] == iit_pkg::SAT16) ? p_rdata[15:0]
                                                          : p_rdata[15:0] + 16'd1;
    assign dlen_inc  = (d_rdata == iit_pkg::SAT16) ? d_rdata : d_rdata + 16'd1;

    // masked compare of a stored term against the token
    always_comb
    begin
        match = t_rdata[TROW-1 -: LW] == len_reg[LW-1:0];
        for (int j = 0; j < TERM_CHARS; j++)
        begin
            if (32'(len_reg) > j && t_rdata[j*8 +: 8] != bytes_reg[j*8 +: 8])
            begin
                match = 1'b0;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        doc_next     = doc_reg;
        bytes_next   = bytes_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        pj_next      = pj_reg;
        used_next    = used_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        freq_next    = freq_reg;
        dlen_next    = dlen_reg;
        bump_next    = bump_reg;
        clr_next     = clr_reg;
        ovalid_next  = ovalid_reg && !res.ready;
        ostatus_next = ostatus_reg;
        oindex_next  = oindex_reg;
        ofreq_next   = ofreq_reg;
        odlen_next   = odlen_reg;
        ocount_next  = ocount_reg;
        ototal_next  = ototal_reg;
        t_we         = 1'b0;
        u_we         = 1'b0;
        u_waddr      = slot_reg;
        u_wdata      = used_reg + 1'b1;
        p_we         = 1'b0;
        p_wdata      = {doc_reg, 16'd1};
        d_we         = 1'b0;
        d_waddr      = clr_reg;
        d_wdata      = '0;
        unique case (state_reg)
            S_INIT, S_CLR:
            begin
                d_we     = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == DOCS - 1)
                begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_EMIT;
                end
            end
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    len_next   = job_len;
                    doc_next   = pop_data[BYW +: 10];
                    bytes_next = pop_data[BYW-1:0];
                    idx_next   = '0;
                    base_next  = '0;
                    pj_next    = '0;
                    slot_next  = '0;
                    freq_next  = '0;
                    dlen_next  = '0;
                    bump_next  = 1'b0;
                    unique case (job_kind)
                        iit_pkg::JOB_CLEAR:
                        begin
                            count_next  = '0;
                            status_next = iit_pkg::ST_CLEARED;
                            clr_next    = '0;
                            state_next  = S_CLR;
                        end
                        iit_pkg::JOB_TOKEN:
                        begin
                            total_next = total_reg + 32'd1;
                            if (32'(job_len) >= TERM_CHARS - 1 || count_reg == '0)
                            begin
                                state_next = S_NEW;
                            end
                            else
                            begin
                                state_next = S_TRD;
                            end
                        end
                        default:
                        begin
                            status_next = iit_pkg::ST_IGNORED;
                            state_next  = S_EMIT;
                        end
                    endcase
                end
            end
            S_TRD:
            begin
                state_next = S_TCMP;
            end
            S_TCMP:
            begin
                if (match)
                begin
                    slot_next  = idx_reg[SW-1:0];
                    used_next  = u_rdata;
                    state_next = S_PRD;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    base_next = base_reg + PAW'(POSTINGS_PER_TERM);
                    state_next = (idx_reg + 1'b1 == count_reg) ? S_NEW : S_TRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                if (p_rdata[25:16] == doc_reg)
                begin
                    p_we        = 1'b1;
                    p_wdata     = {doc_reg, cnt_inc};
                    freq_next   = cnt_inc;
                    status_next = iit_pkg::ST_FREQ;
                    bump_next   = 1'b1;
                    state_next  = S_DOC;
                end
                else
                begin
                    pj_next    = pj_reg + 1'b1;
                    state_next = (pj_reg + 1'b1 == used_reg) ? S_PEND : S_PRD;
                end
            end
            S_PEND:
            begin
                if (32'(used_reg) < POSTINGS_PER_TERM)
                begin
                    p_we        = 1'b1;
                    u_we        = 1'b1;
                    freq_next   = 16'd1;
                    status_next = iit_pkg::ST_ADDED;
                    bump_next   = 1'b1;
                end
                else
                begin
                    status_next = iit_pkg::ST_POST_FULL;
                end
                state_next = S_DOC;
            end
            S_NEW:
            begin
                if (32'(count_reg) >= TERMS)
                begin
                    status_next = iit_pkg::ST_TABLE_FULL;
                end
                else if (32'(len_reg) >= TERM_CHARS - 1)
                begin
                    status_next = iit_pkg::ST_TOO_LONG;
                end
                else
                begin
                    t_we        = 1'b1;
                    u_we        = 1'b1;
                    u_waddr     = count_reg[SW-1:0];
                    u_wdata     = PPW'(1);
                    p_we        = 1'b1;
                    slot_next   = count_reg[SW-1:0];
                    count_next  = count_reg + 1'b1;
                    freq_next   = 16'd1;
                    status_next = iit_pkg::ST_NEW;
                    bump_next   = 1'b1;
                end
                state_next = S_DOC;
            end
            S_DOC:
            begin
                d_waddr = DAW'(doc_reg);
                d_wdata = dlen_inc;
                if (bump_reg)
                begin
                    d_we      = 1'b1;
                    dlen_next = dlen_inc;
                end
                else
                begin
                    dlen_next = d_rdata;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    oindex_next  = 10'(slot_reg);
                    ofreq_next   = freq_reg;
                    odlen_next   = dlen_reg;
                    ocount_next  = 11'(count_reg);
                    ototal_next  = total_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            len_reg     <= '0;
            doc_reg     <= '0;
            bytes_reg   <= '0;
            idx_reg     <= '0;
            base_reg    <= '0;
            pj_reg      <= '0;
            used_reg    <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            status_reg  <= iit_pkg::ST_IGNORED;
            slot_reg    <= '0;
            freq_reg    <= '0;
            dlen_reg    <= '0;
            bump_reg    <= 1'b0;
            clr_reg     <= '0;
            ovalid_reg  <= 1'b0;
            ostatus_reg <= '0;
            oindex_reg  <= '0;
            ofreq_reg   <= '0;
            odlen_reg   <= '0;
            ocount_reg  <= '0;
            ototal_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            doc_reg     <= doc_next;
            bytes_reg   <= bytes_next;
            idx_reg     <= idx_next;
            base_reg    <= base_next;
            pj_reg      <= pj_next;
            used_reg    <= used_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            freq_reg    <= freq_next;
            dlen_reg    <= dlen_next;
            bump_reg    <= bump_next;
            clr_reg     <= clr_next;
            ovalid_reg  <= ovalid_next;
            ostatus_reg <= ostatus_next;
            oindex_reg  <= oindex_next;
            ofreq_reg   <= ofreq_next;
            odlen_reg   <= odlen_next;
            ocount_reg  <= ocount_next;
            ototal_reg  <= ototal_next;
        end
    end

    assign res.valid        = ovalid_reg;
    assign res.status       = ostatus_reg;
    assign res.term_index   = oindex_reg;
    assign res.posting_freq = ofreq_reg;
    assign res.doc_length   = odlen_reg;
    assign res.term_count   = ocount_reg;
    assign res.token_total  = ototal_reg;

    // checks
    `IIT_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= TERMS)
    `IIT_ASSERT_IMPLY(a_posting_bound, clk, rst_n, state_reg == S_PCMP, 32'(pj_reg) < POSTINGS_PER_TERM && pj_reg < used_reg)
    `IIT_ASSERT_NEXT(a_clear_empties, clk, rst_n, state_reg == S_IDLE && pop_valid && job_kind == iit_pkg::JOB_CLEAR, count_reg == '0 && state_reg == S_CLR)
endmodule

// ----- hw/rtl/inverted_index_token_insert.sv -----
// Inverted index insert. An append request only stores a byte. An end-of-token request scans the
// stored terms in insertion order (term row memory read and compare), then the postings of the
// matched term, then does the update and result. A clear request sweeps the document length
// memory, one row per cycle. After reset the same sweep runs before the first request is
// taken. A two-entry queue lets bytes keep arriving while a lookup runs, until it is full.
module inverted_index_token_insert #(
    parameter int TERMS             = iit_pkg::TERMS_DEF,
    parameter int POSTINGS_PER_TERM = iit_pkg::POSTINGS_PER_TERM_DEF,
    parameter int DOCS              = iit_pkg::DOCS_DEF,
    parameter int TERM_CHARS        = iit_pkg::TERM_CHARS_DEF,
    parameter int MAX_TOKEN_CHARS   = iit_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    iit_in_if.sink    tok,
    iit_out_if.source res
);
    localparam int JOB_W = 19 + 8 * TERM_CHARS;

    logic             push_valid, push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [JOB_W-1:0] pop_data;
    logic             init_done;

    // request intake
    iit_front #(
        .TERM_CHARS(TERM_CHARS), .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
        .DOCS(DOCS), .JOB_W(JOB_W)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .tok(tok), .enable(init_done),
        .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
    );

    // job queue
    iit_queue #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
    );

    // index update
    iit_back #(
        .TERMS(TERMS), .POSTINGS_PER_TERM(POSTINGS_PER_TERM), .DOCS(DOCS),
        .TERM_CHARS(TERM_CHARS), .JOB_W(JOB_W)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
        .init_done(init_done), .res(res)
    );
endmodule

// ----- test/tb_inverted_index_token_insert.sv -----
// testbench of the inverted index token insert block
`timescale 1ns / 100ps

module tb_inverted_index_token_insert;
    localparam int NTERMS = iit_pkg::TERMS_DEF;
    localparam int NPOST  = iit_pkg::POSTINGS_PER_TERM_DEF;
    localparam int NDOCS  = iit_pkg::DOCS_DEF;
    localparam int NCHARS = iit_pkg::TERM_CHARS_DEF;
    localparam int NMAXTOK = iit_pkg::MAX_TOKEN_CHARS_DEF;

    typedef struct {
        iit_pkg::cmd_t cmd;
        logic [7:0]    ch;
        logic [9:0]    doc;
        bit            hold;
    } request_t;

    typedef struct {
        iit_pkg::status_t status;
        logic [9:0]       term_index;
        logic [15:0]      posting_freq;
        logic [15:0]      doc_length;
        logic [10:0]      term_count;
        logic [31:0]      token_total;
    } index_result_t;

    logic clk;
    logic rst_n;

    iit_in_if  tok ();
    iit_out_if res ();

    inverted_index_token_insert i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok.sink),
        .res   (res.source)
    );

    // mirror of the index contents
    logic [7:0]  buf_bytes [NCHARS];
    int unsigned buf_len;
    logic [7:0]  stored_bytes [NTERMS][NCHARS];
    int unsigned stored_len [NTERMS];
    int unsigned used_postings [NTERMS];
    logic [9:0]  post_doc [NTERMS][NPOST];
    logic [15:0] post_freq [NTERMS][NPOST];
    int unsigned n_terms;
    logic [15:0] doc_len [NDOCS];
    logic [31:0] n_accepted;

    request_t      pending [$];
    index_result_t results_due [$];
    int unsigned   errors;
    int unsigned   cyc;
    bit            in_taken;
    int            rx_hold;

    always #6 clk = ~clk;

    function automatic index_result_t make_result(iit_pkg::status_t st, int unsigned slot,
                                                  int unsigned freq, int unsigned dl);
        index_result_t r;
        r.status       = st;
        r.term_index   = slot[9:0];
        r.posting_freq = freq[15:0];
        r.doc_length   = dl[15:0];
        r.term_count   = n_terms[10:0];
        r.token_total  = n_accepted;
        return r;
    endfunction

    function automatic int unsigned bump_doc(int unsigned d);
        if (doc_len[d] != iit_pkg::SAT16)
            doc_len[d] = doc_len[d] + 16'd1;
        return doc_len[d];
    endfunction

    // close the buffered token and update the mirror
    function automatic index_result_t close_token(int unsigned d);
        int unsigned len;
        int          slot;
        int unsigned s;
        int unsigned n;
        bit          same;
        len = buf_len;
        slot = -1;
        buf_len = 0;
        if (len == 0 || len > NMAXTOK || d >= NDOCS)
            return make_result(iit_pkg::ST_IGNORED, 0, 0, 0);
        n_accepted = n_accepted + 32'd1;
        if (len < NCHARS - 1) begin
            for (int i = 0; i < n_terms && slot < 0; i++) begin
                same = (stored_len[i] == len);
                for (int k = 0; k < len && same; k++)
                    if (stored_bytes[i][k] != buf_bytes[k])
                        same = 0;
                if (same)
                    slot = i;
            end
        end
        if (slot >= 0) begin
            s = slot;
            n = used_postings[s];
            for (int j = 0; j < n; j++) begin
                if (post_doc[s][j] == d) begin
                    if (post_freq[s][j] != iit_pkg::SAT16)
                        post_freq[s][j] = post_freq[s][j] + 16'd1;
                    return make_result(iit_pkg::ST_FREQ, s, post_freq[s][j], bump_doc(d));
                end
            end
            if (n < NPOST) begin
                post_doc[s][n] = d;
                post_freq[s][n] = 1;
                used_postings[s] = n + 1;
                return make_result(iit_pkg::ST_ADDED, s, 1, bump_doc(d));
            end
            return make_result(iit_pkg::ST_POST_FULL, s, 0, doc_len[d]);
        end
        if (n_terms >= NTERMS)
            return make_result(iit_pkg::ST_TABLE_FULL, 0, 0, doc_len[d]);
        if (len >= NCHARS - 1)
            return make_result(iit_pkg::ST_TOO_LONG, 0, 0, doc_len[d]);
        s = n_terms;
        for (int k = 0; k < len; k++)
            stored_bytes[s][k] = buf_bytes[k];
        stored_len[s] = len;
        post_doc[s][0] = d;
        post_freq[s][0] = 1;
        used_postings[s] = 1;
        n_terms = s + 1;
        return make_result(iit_pkg::ST_NEW, s, 1, bump_doc(d));
    endfunction

    // apply one accepted request to the mirror, queueing any result
    function automatic void apply_request(iit_pkg::cmd_t c, logic [7:0] ch, logic [9:0] d);
        case (c)
            iit_pkg::CMD_APPEND:
            begin
                if (buf_len < NCHARS)
                    buf_bytes[buf_len] = ch;
                if (buf_len < iit_pkg::LEN_MAX)
                    buf_len++;
            end
            iit_pkg::CMD_END:
                results_due.push_back(close_token(d));
            iit_pkg::CMD_CLEAR:
            begin
                n_terms = 0;
                foreach (doc_len[i])
                    doc_len[i] = 0;
                results_due.push_back(make_result(iit_pkg::ST_CLEARED, 0, 0, 0));
            end
            default:
                ;
        endcase
    endfunction

    task automatic flag_mismatch(string field, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, field, got, want);
        errors++;
    endtask

    // request stimulus helpers
    function automatic void put(iit_pkg::cmd_t c, int unsigned ch, int unsigned d);
        request_t r;
        r.cmd  = c;
        r.ch   = ch[7:0];
        r.doc  = d[9:0];
        r.hold = 0;
        pending.push_back(r);
    endfunction

    function automatic void put_hold();
        request_t r;
        r.cmd  = iit_pkg::CMD_NONE;
        r.ch   = 0;
        r.doc  = 0;
        r.hold = 1;
        pending.push_back(r);
    endfunction

    function automatic void put_token(int unsigned len, int unsigned seed_ch, int unsigned d);
        for (int k = 0; k < len; k++)
            put(iit_pkg::CMD_APPEND, seed_ch + k, 0);
        put(iit_pkg::CMD_END, 0, d);
    endfunction

    function automatic bit calm();
        return cyc >= 2500 && cyc < 4500;
    endfunction

    // acceptance and result checking at the rising edge
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        in_taken = 0;
        if (rst_n && tok.valid && tok.ready)
        begin
            apply_request(iit_pkg::cmd_t'(tok.cmd), tok.token_char, tok.doc_id);
            in_taken = 1;
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cyc);
                errors++;
            end
            else
            begin
                index_result_t w;
                w = results_due.pop_front();
                if (res.status != w.status)
                    flag_mismatch("status", res.status, w.status);
                if (res.term_index != w.term_index)
                    flag_mismatch("term_index", res.term_index, w.term_index);
                if (res.posting_freq != w.posting_freq)
                    flag_mismatch("posting_freq", res.posting_freq, w.posting_freq);
                if (res.doc_length != w.doc_length)
                    flag_mismatch("doc_length", res.doc_length, w.doc_length);
                if (res.term_count != w.term_count)
                    flag_mismatch("term_count", res.term_count, w.term_count);
                if (res.token_total != w.token_total)
                    flag_mismatch("token_total", res.token_total, w.token_total);
            end
        end
    end

    // request driver on the falling edge, a waiting request stays offered
    always @(negedge clk)
    begin
        if (in_taken)
            void'(pending.pop_front());
        if (pending.size() > 0 && pending[0].hold && results_due.size() == 0)
            void'(pending.pop_front());
        if (pending.size() > 0 && !pending[0].hold && rst_n &&
            ((tok.valid && !in_taken) || calm() || $urandom_range(0, 99) >= 30))
        begin
            tok.valid      <= 1'b1;
            tok.cmd        <= pending[0].cmd;
            tok.token_char <= pending[0].ch;
            tok.doc_id     <= pending[0].doc;
        end
        else
        begin
            tok.valid <= 1'b0;
        end
    end

    // result back-pressure, with one long hold-off
    always @(negedge clk)
    begin
        if (cyc == 1500)
            rx_hold = 600;
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= calm() || $urandom_range(0, 99) >= 30;
        end
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned n;
        int unsigned len;
        int unsigned alpha;
        clk = 0;
        rst_n = 0;
        cyc = 0;
        errors = 0;
        rx_hold = 0;
        in_taken = 0;
        tok.valid = 0;
        tok.cmd = iit_pkg::CMD_NONE;
        tok.token_char = 0;
        tok.doc_id = 0;
        res.ready = 0;
        buf_len = 0;
        n_terms = 0;
        n_accepted = 0;
        foreach (doc_len[i])
            doc_len[i] = 0;

        // directed: empty token, new term, repeat, second doc, extremes of bytes
        put(iit_pkg::CMD_END, 0, 0);
        put_token(1, 0, 0);
        put_token(1, 0, 0);
        put_token(1, 0, 1023);
        put_token(1, 255, 1023);
        put(iit_pkg::CMD_NONE, 255, 1023);
        // longest storable term, then too long ones, then a saturated length
        put_token(30, 16, 7);
        put_token(30, 16, 7);
        put_token(31, 16, 7);
        put_token(100, 1, 8);
        put_token(128, 1, 8);
        // clear keeps a partial token
        put(iit_pkg::CMD_APPEND, 8'h61, 0);
        put(iit_pkg::CMD_APPEND, 8'h62, 0);
        put(iit_pkg::CMD_CLEAR, 0, 0);
        put(iit_pkg::CMD_APPEND, 8'h63, 0);
        put(iit_pkg::CMD_END, 0, 682);
        put(iit_pkg::CMD_END, 0, 341);
        // posting list overflow on one term
        for (int d = 0; d <= NPOST; d++)
            put_token(1, 170, d);
        put_token(1, 170, 3);
        put_hold();

        // random: mostly short tokens over a small alphabet
        alpha = 4;
        n = 0;
        while (n < 40)
        begin
            case ($urandom_range(0, 99)) inside
                [0:1]:
                begin
                    put(iit_pkg::CMD_CLEAR, $urandom, $urandom);
                    n++;
                end
                [2:4]:
                    put(iit_pkg::CMD_NONE, $urandom, $urandom);
                [5:7]:
                begin
                    len = $urandom_range(0, 1) ? $urandom_range(29, 33) :
                        $urandom_range(99, 102);
                    for (int k = 0; k < len; k++)
                        put(iit_pkg::CMD_APPEND, $urandom, 0);
                    put(iit_pkg::CMD_END, 0, $urandom_range(0, 1023));
                    n += len + 1;
                end
                default:
                begin
                    len = $urandom_range(0, 3);
                    for (int k = 0; k < len; k++)
                        put(iit_pkg::CMD_APPEND, $urandom_range(0, 9) == 0 ? $urandom :
                            $urandom_range(0, alpha - 1), 0);
                    put(iit_pkg::CMD_END, 0, $urandom_range(0, 3) == 0 ?
                        $urandom_range(0, 1023) : $urandom_range(0, 5));
                    n += len + 1;
                end
            endcase
            if (n % 20 < 2)
                put_hold();
        end
        put_hold();

        wait (pending.size() == 0 && results_due.size() == 0);
        repeat (2000) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // reset
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end
endmodule
